// ===== hw/rtl/cptd_pkg.sv =====
// Package with the constants and types shared by the planar tile decoder.
`timescale 1ns / 1ps

package cptd_pkg;

    // Tile layout of the pattern tables.
    localparam int TILES_PER_ROW   = 16;
    localparam int TILES_PER_TABLE = 256;
    localparam int TABLE_COUNT     = 2;

    // Bytes and rows of one tile.
    localparam int ROWS_PER_TILE  = 8;
    localparam int BYTES_PER_TILE = 16;
    localparam int POS_W          = $clog2(BYTES_PER_TILE);
    localparam int ROW_AW         = $clog2(ROWS_PER_TILE);

    // Counter widths, wide enough to hold the wrap limit itself.
    localparam int COL_CW = $clog2(TILES_PER_ROW + 1);
    localparam int ROW_CW = $clog2(TILES_PER_TABLE + 1);
    localparam int TAB_CW = $clog2(TABLE_COUNT + 1);
    localparam int IDX_W  = $clog2(TILES_PER_TABLE + TILES_PER_ROW + 1) + 1;

    // Field widths of the words on the channels.
    localparam int BYTE_W   = 8;
    localparam int TABLE_W  = 1;
    localparam int TCOL_W   = 4;
    localparam int TROW_W   = 4;
    localparam int PIX_W    = 3;
    localparam int COLOUR_W = 3;

    // Position of a row in flight through the decoder.
    typedef struct packed {
        logic [TAB_CW-1:0] table_num;
        logic [COL_CW-1:0] tile_col;
        logic [ROW_CW-1:0] tile_row;
        logic [ROW_AW-1:0] row;
    } row_meta_t;

endpackage

// ===== hw/rtl/cptd_if.sv =====
// Handshake interfaces for the pattern byte input and the pixel output.
`timescale 1ns / 1ps

interface cptd_in_if;
    logic                        valid;
    logic                        ready;
    logic [cptd_pkg::BYTE_W-1:0] chr_byte;

    modport source (output valid, output chr_byte, input ready);
    modport sink (input valid, input chr_byte, output ready);
endinterface

interface cptd_out_if;
    logic                          valid;
    logic                          ready;
    logic [cptd_pkg::TABLE_W-1:0]  table_select;
    logic [cptd_pkg::TCOL_W-1:0]   tile_column;
    logic [cptd_pkg::TROW_W-1:0]   tile_row;
    logic [cptd_pkg::PIX_W-1:0]    pixel_x;
    logic [cptd_pkg::PIX_W-1:0]    pixel_y;
    logic [cptd_pkg::COLOUR_W-1:0] colour_code;
    logic                          last;

    modport source (output valid, output table_select, output tile_column, output tile_row,
                    output pixel_x, output pixel_y, output colour_code, output last,
                    input ready);
    modport sink (input valid, input table_select, input tile_column, input tile_row,
                  input pixel_x, input pixel_y, input colour_code, input last,
                  output ready);
endinterface

// ===== hw/rtl/chr_planar_tile_decode_top.sv =====
// Top level of the planar tile decoder: row store, merge stage and pixel emitter.
//
//  channel   dir  word
//  chr_in    in   one pattern byte (chr_byte)
//  pix_out   out  one nonzero pixel (table, tile, x, y, colour code, last)
//
// A low-plane byte is written into the eight-entry row memory.
// A high-plane byte reads its row from that memory into the merge stage, and
// the merged row then moves into the emitter once it is free, which sends one
// pixel per cycle while pix_out is ready, eight at most; an all-zero row sends none.
// Reset clears all control state; the row memory is not cleared.
// A stall on pix_out holds the emitter, then the merge stage, then chr_in.
`timescale 1ns / 1ps

module chr_planar_tile_decode_top (
    input logic clk,
    input logic rst_n,
    cptd_in_if.sink    chr_in,
    cptd_out_if.source pix_out
);
    import cptd_pkg::*;

    // Row memory for the low plane of the current tile.
    logic [BYTE_W-1:0] row_mem [ROWS_PER_TILE];
    logic [BYTE_W-1:0] rd_data_reg;

    // Byte position and tile position counters.
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [COL_CW-1:0] col_reg, col_next;
    logic [ROW_CW-1:0] trow_reg, trow_next;
    logic [TAB_CW-1:0] tab_reg, tab_next;

    // Merge stage, waiting on the memory read.
    logic              s1_valid_reg, s1_valid_next;
    row_meta_t         s1_meta_reg;
    logic [BYTE_W-1:0] s1_hi_reg;

    // Emitter holding the remaining pixels of one row, in x order.
    logic              em_valid_reg, em_valid_next;
    logic [BYTE_W-1:0] em_mask_reg, em_mask_next;
    logic [BYTE_W-1:0] em_hi_reg;
    logic [BYTE_W-1:0] em_lo_reg;
    row_meta_t         em_meta_reg;

    logic              in_fire;
    logic              hi_plane;
    logic              out_fire;
    logic              s1_go;
    logic              em_free;
    logic              em_one_left;
    logic              em_load;
    logic [BYTE_W-1:0] s1_hi_rev;
    logic [BYTE_W-1:0] s1_lo_rev;
    logic [BYTE_W-1:0] s1_mask;
    logic [PIX_W-1:0]  em_x;
    logic [COL_CW-1:0] col_inc;
    logic [ROW_CW-1:0] trow_inc;
    logic [TAB_CW-1:0] tab_inc;
    logic [COL_CW-1:0] col_wrap;
    logic [ROW_CW-1:0] trow_wrap;
    logic [IDX_W-1:0]  tile_idx;

    assign hi_plane = pos_reg[POS_W-1];
    assign in_fire  = chr_in.valid && chr_in.ready;
    assign out_fire = em_valid_reg && pix_out.ready;

    // Memory: a low-plane byte writes its row, a high-plane byte reads it.
    always_ff @(posedge clk)
    begin
        if (in_fire && !hi_plane)
        begin
            row_mem[pos_reg[ROW_AW-1:0]] <= chr_in.chr_byte;
        end
        if (in_fire && hi_plane)
        begin
            rd_data_reg <= row_mem[pos_reg[ROW_AW-1:0]];
        end
    end

    // Merge the two planes, reversed so that bit x is pixel x.
    always_comb
    begin
        for (int i = 0; i < BYTE_W; i++)
        begin
            s1_hi_rev[i] = s1_hi_reg[BYTE_W-1-i];
            s1_lo_rev[i] = rd_data_reg[BYTE_W-1-i];
        end
        s1_mask = s1_hi_rev | s1_lo_rev;
    end

    // Handshake between the stages.
    assign em_one_left = (em_mask_reg & (em_mask_reg - BYTE_W'(1))) == '0;
    assign em_free     = !em_valid_reg || (pix_out.ready && em_one_left);
    assign s1_go       = s1_valid_reg && ((s1_mask == '0) || em_free);
    assign em_load     = s1_go && (s1_mask != '0);
    assign chr_in.ready = !s1_valid_reg || s1_go;

    // Tile position advance after the last byte of a tile.
    always_comb
    begin
        pos_next  = pos_reg;
        col_next  = col_reg;
        trow_next = trow_reg;
        tab_next  = tab_reg;
        col_inc   = col_reg + COL_CW'(1);
        trow_inc  = trow_reg + ROW_CW'(1);
        tab_inc   = tab_reg + TAB_CW'(1);
        col_wrap  = col_inc;
        trow_wrap = trow_reg;
        if (col_inc >= COL_CW'(TILES_PER_ROW))
        begin
            col_wrap  = '0;
            trow_wrap = trow_inc;
        end
        tile_idx = IDX_W'(trow_wrap) * IDX_W'(TILES_PER_ROW) + IDX_W'(col_wrap);
        if (in_fire)
        begin
            pos_next = pos_reg + POS_W'(1);
            if (pos_reg == POS_W'(BYTES_PER_TILE - 1))
            begin
                col_next  = col_wrap;
                trow_next = trow_wrap;
                if (tile_idx >= IDX_W'(TILES_PER_TABLE))
                begin
                    col_next  = '0;
                    trow_next = '0;
                    tab_next  = (tab_inc >= TAB_CW'(TABLE_COUNT)) ? '0 : tab_inc;
                end
            end
        end
    end

    // Next state of the merge stage and the emitter.
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire && hi_plane)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end

        em_valid_next = em_valid_reg;
        em_mask_next  = em_mask_reg;
        if (em_load)
        begin
            em_valid_next = 1'b1;
            em_mask_next  = s1_mask;
        end
        else if (out_fire)
        begin
            em_mask_next = em_mask_reg & (em_mask_reg - BYTE_W'(1));
            if (em_one_left)
            begin
                em_valid_next = 1'b0;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            col_reg      <= '0;
            trow_reg     <= '0;
            tab_reg      <= '0;
            s1_valid_reg <= 1'b0;
            em_valid_reg <= 1'b0;
            em_mask_reg  <= '0;
        end
        else
        begin
            pos_reg      <= pos_next;
            col_reg      <= col_next;
            trow_reg     <= trow_next;
            tab_reg      <= tab_next;
            s1_valid_reg <= s1_valid_next;
            em_valid_reg <= em_valid_next;
            em_mask_reg  <= em_mask_next;
        end
    end

    // Payload registers of the merge stage and the emitter.
    always_ff @(posedge clk)
    begin
        if (in_fire && hi_plane)
        begin
            s1_hi_reg             <= chr_in.chr_byte;
            s1_meta_reg.table_num <= tab_reg;
            s1_meta_reg.tile_col  <= col_reg;
            s1_meta_reg.tile_row  <= trow_reg;
            s1_meta_reg.row       <= pos_reg[ROW_AW-1:0];
        end
        if (em_load)
        begin
            em_hi_reg   <= s1_hi_rev;
            em_lo_reg   <= s1_lo_rev;
            em_meta_reg <= s1_meta_reg;
        end
    end

    // Lowest remaining pixel is the next one out.
    always_comb
    begin
        em_x = '0;
        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            if (em_mask_reg[i])
            begin
                em_x = PIX_W'(i);
            end
        end
    end

    // Output word.
    assign pix_out.valid        = em_valid_reg;
    assign pix_out.table_select = TABLE_W'(em_meta_reg.table_num);
    assign pix_out.tile_column  = TCOL_W'(em_meta_reg.tile_col);
    assign pix_out.tile_row     = TROW_W'(em_meta_reg.tile_row);
    assign pix_out.pixel_x      = em_x;
    assign pix_out.pixel_y      = PIX_W'(em_meta_reg.row);
    assign pix_out.colour_code  = COLOUR_W'({em_hi_reg[em_x], em_lo_reg[em_x]}) +
                                  COLOUR_W'(1);
    assign pix_out.last         = em_one_left;

    // An active emitter always has a pixel left to send.
    a_em_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        em_valid_reg |-> (em_mask_reg != '0))
        else $error("emitter active with no pixel left");

    // A high-plane byte always reaches the merge stage.
    a_s1_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && hi_plane) |=> s1_valid_reg)
        else $error("high-plane byte lost before the merge stage");

    // A stalled merge stage keeps its row.
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_go) |=> (s1_valid_reg && $stable(s1_meta_reg)))
        else $error("merge stage changed while stalled");

    // A byte is taken only when the merge stage can make room.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s1_valid_reg) |-> s1_go)
        else $error("byte taken over a stalled merge stage");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the planar tile decoder top level.
`timescale 1ns / 1ps

module testbench;

    import cptd_pkg::*;

    // Cycles of quiet after the last pixel, the no-progress limit and the hold-off length.
    localparam int SETTLE_CYCLES = 32;
    localparam int STALL_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 400;

    // One pixel word as it appears on the output channel.
    typedef struct packed {
        logic [TABLE_W-1:0]  table_select;
        logic [TCOL_W-1:0]   tile_column;
        logic [TROW_W-1:0]   tile_row;
        logic [PIX_W-1:0]    pixel_x;
        logic [PIX_W-1:0]    pixel_y;
        logic [COLOUR_W-1:0] colour_code;
        logic                last;
    } pixel_t;

    logic clk;
    logic rst_n;

    cptd_in_if  chr_bus ();
    cptd_out_if pix_bus ();

    chr_planar_tile_decode_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .chr_in  (chr_bus.sink),
        .pix_out (pix_bus.source)
    );

    // Bytes waiting to be offered and pixels the decoder still owes.
    logic [BYTE_W-1:0] pending_bytes[$];
    pixel_t            expected_pixels[$];

    // Shadow copy of the decoder's row store and tile position.
    logic [7:0] low_rows[ROWS_PER_TILE];
    int         byte_pos;
    int         col_count;
    int         row_count;
    int         tab_count;
    int         position_wraps;

    int  tx_idle_pct;
    int  rx_idle_pct;
    logic rx_hold;
    logic hold_go;
    int  bytes_sent;
    int  pixels_seen;
    int  error_count;
    int  stall_cycles;
    int  last_sent;
    int  last_seen;

    // Merges one accepted byte into the shadow state and queues its pixels.
    task automatic decode_chr_byte(input logic [BYTE_W-1:0] value);
        logic [7:0] low;
        logic [7:0] merged;
        logic [1:0] index;
        pixel_t     px;
        int         row;
        begin
            if (byte_pos < ROWS_PER_TILE)
            begin
                low_rows[byte_pos] = value;
            end
            else
            begin
                row    = byte_pos - ROWS_PER_TILE;
                low    = low_rows[row];
                merged = low | value;
                for (int x = 0; x < 8; x++)
                begin
                    index = {value[7-x], low[7-x]};
                    if (index != 2'd0)
                    begin
                        px.table_select = TABLE_W'(tab_count);
                        px.tile_column  = TCOL_W'(col_count);
                        px.tile_row     = TROW_W'(row_count);
                        px.pixel_x      = PIX_W'(x);
                        px.pixel_y      = PIX_W'(row);
                        px.colour_code  = COLOUR_W'(index) + COLOUR_W'(1);
                        // Last when no nonzero pixel lies further right in this row.
                        px.last         = ((merged & ((8'h01 << (7 - x)) - 8'h01)) == 8'h00);
                        expected_pixels.push_back(px);
                    end
                end
            end

            // Step through the tile, then through columns, rows and tables.
            byte_pos++;
            if (byte_pos >= BYTES_PER_TILE)
            begin
                byte_pos = 0;
                col_count++;
                if (col_count >= TILES_PER_ROW)
                begin
                    col_count = 0;
                    row_count++;
                end
                if (row_count * TILES_PER_ROW + col_count >= TILES_PER_TABLE)
                begin
                    col_count = 0;
                    row_count = 0;
                    tab_count++;
                    if (tab_count >= TABLE_COUNT)
                    begin
                        tab_count = 0;
                        position_wraps++;
                    end
                end
            end
        end
    endtask

    // Random byte with the all-zero and all-one extremes weighted up.
    function automatic logic [BYTE_W-1:0] random_byte();
        int pick;
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                random_byte = 8'h00;
            else if (pick == 1)
                random_byte = 8'hFF;
            else
                random_byte = BYTE_W'($urandom_range(0, 255));
        end
    endfunction

    task automatic queue_byte(input logic [BYTE_W-1:0] value);
        begin
            pending_bytes.push_back(value);
        end
    endtask

    task automatic queue_random_tiles(input int tiles);
        begin
            for (int i = 0; i < tiles * BYTES_PER_TILE; i++)
                queue_byte(random_byte());
        end
    endtask

    // Holds the stimulus until every queued byte is taken and every pixel seen.
    task automatic wait_for_drain();
        begin
            while (pending_bytes.size() != 0 || chr_bus.valid || expected_pixels.size() != 0)
                @(negedge clk);
            repeat (SETTLE_CYCLES) @(negedge clk);
        end
    endtask

    // Clock and reset.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Known values on every input before the first edge.
    initial
    begin
        chr_bus.valid    = 1'b0;
        chr_bus.chr_byte = '0;
        pix_bus.ready    = 1'b0;
    end

    // Driver: offers the next byte and keeps it steady until it is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chr_bus.valid    <= 1'b0;
            chr_bus.chr_byte <= '0;
        end
        else
        begin
            if (chr_bus.valid && chr_bus.ready)
            begin
                decode_chr_byte(chr_bus.chr_byte);
                bytes_sent <= bytes_sent + 1;
            end
            if (chr_bus.valid && !chr_bus.ready)
            begin
                chr_bus.valid <= 1'b1;
            end
            else if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct)
            begin
                chr_bus.valid    <= 1'b1;
                chr_bus.chr_byte <= pending_bytes.pop_front();
            end
            else
            begin
                chr_bus.valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each pixel word against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_bus.ready <= 1'b0;
        end
        else
        begin
            if (pix_bus.valid && pix_bus.ready)
            begin
                pixels_seen <= pixels_seen + 1;
                if (expected_pixels.size() == 0)
                begin
                    $display("%0t: unexpected tab=%0d col=%0d row=%0d x=%0d y=%0d c=%0d last=%0d",
                             $time, pix_bus.table_select, pix_bus.tile_column,
                             pix_bus.tile_row, pix_bus.pixel_x, pix_bus.pixel_y,
                             pix_bus.colour_code, pix_bus.last);
                    error_count++;
                end
                else
                begin
                    pixel_t want;
                    pixel_t got;
                    want = expected_pixels.pop_front();
                    got  = {pix_bus.table_select, pix_bus.tile_column, pix_bus.tile_row,
                            pix_bus.pixel_x, pix_bus.pixel_y, pix_bus.colour_code,
                            pix_bus.last};
                    if (got !== want)
                    begin
                        $display("%0t: expected tab=%0d col=%0d row=%0d x=%0d y=%0d c=%0d l=%0d",
                                 $time, want.table_select, want.tile_column, want.tile_row,
                                 want.pixel_x, want.pixel_y, want.colour_code, want.last);
                        $display("%0t:   actual tab=%0d col=%0d row=%0d x=%0d y=%0d c=%0d l=%0d",
                                 $time, got.table_select, got.tile_column, got.tile_row,
                                 got.pixel_x, got.pixel_y, got.colour_code, got.last);
                        error_count++;
                    end
                end
            end
            pix_bus.ready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Long receiver hold-off so the decoder backs up into its input.
    initial
    begin
        rx_hold = 1'b0;
        wait (hold_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // Watchdog: ends the run when work is outstanding but nothing moves.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (bytes_sent != last_sent || pixels_seen != last_seen)
                stall_cycles = 0;
            else if (pending_bytes.size() != 0 || chr_bus.valid || expected_pixels.size() != 0)
                stall_cycles++;
            last_sent = bytes_sent;
            last_seen = pixels_seen;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles, %0d pixels outstanding",
                         $time, stall_cycles, expected_pixels.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Stimulus: directed tile, then random tiles through the first tile row and beyond.
    initial
    begin
        byte_pos       = 0;
        col_count      = 0;
        row_count      = 0;
        tab_count      = 0;
        position_wraps = 0;
        tx_idle_pct    = 27;
        rx_idle_pct    = 79;
        hold_go        = 1'b0;
        bytes_sent     = 0;
        pixels_seen    = 0;
        error_count    = 0;
        stall_cycles   = 0;
        last_sent      = 0;
        last_seen      = 0;
        for (int i = 0; i < ROWS_PER_TILE; i++)
            low_rows[i] = 8'h00;

        wait (rst_n);
        @(negedge clk);

        // Low plane: full, empty, alternating, nibbles, edges, then empty.
        queue_byte(8'hFF);
        queue_byte(8'h00);
        queue_byte(8'hAA);
        queue_byte(8'h55);
        queue_byte(8'h0F);
        queue_byte(8'hF0);
        queue_byte(8'h81);
        queue_byte(8'h00);
        // High plane: all code 2, an all-zero row, mixed codes 2 to 4, all code 3.
        queue_byte(8'h00);
        queue_byte(8'h00);
        queue_byte(8'hAA);
        queue_byte(8'hAA);
        queue_byte(8'hFF);
        queue_byte(8'h0F);
        queue_byte(8'h7E);
        queue_byte(8'hFF);
        queue_random_tiles(5);
        wait_for_drain();

        // Sender slow, receiver fast.
        tx_idle_pct = 79;
        rx_idle_pct = 27;
        queue_random_tiles(3);
        wait_for_drain();

        // No idling; the receiver holds off while a burst piles up.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_go     = 1'b1;
        queue_random_tiles(5);
        wait_for_drain();

        // Finish the first tile row and step into the second one.
        queue_random_tiles(4);
        wait_for_drain();

        $display("Decoded %0d pattern bytes into %0d pixels; position wrapped %0d time(s).",
                 bytes_sent, pixels_seen, position_wraps);
        $display("Covered both idling mixes, a free-running phase, a long output stall");
        $display("and the step from the first tile row into the second.");
        if (error_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("%0d mismatches", error_count);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
